FILE: rtl/hsga_pkg.sv
// Shared constants, register indexes and controller/datapath command types
// for the histogram split gain search. No dependencies.
`timescale 1ns / 1ps
package hsga_pkg;
  localparam int MAX_BINS = 256;
  localparam int CNT_W    = $clog2(MAX_BINS + 1);
  localparam int DIV_STEPS = 64;
  localparam int DCNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [46:0] TERM_MAX = 47'h7FFF_FFFF_FFFF;
  localparam logic signed [49:0] INVALID_GAIN = -50'sd65536;

  localparam logic [1:0] REG_PARENT_GRAD = 2'd0;
  localparam logic [1:0] REG_PARENT_HESS = 2'd1;
  localparam logic [1:0] REG_L2_LAMBDA   = 2'd2;
  localparam logic [1:0] REG_MIN_HESS    = 2'd3;

  localparam logic [1:0] TERM_LEFT   = 2'd0;
  localparam logic [1:0] TERM_RIGHT  = 2'd1;
  localparam logic [1:0] TERM_PARENT = 2'd2;

  typedef struct packed {
    logic       load_item;
    logic       flag_ovf;
    logic       prep;
    logic       div_step;
    logic       acc;
    logic       update;
    logic       emit;
    logic [1:0] term;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic div_done;
    logic out_free;
  } sts_t;
endpackage

FILE: rtl/hsga_if.sv
// Channel interfaces: bin input, split result output, configuration write.
// Depends on nothing.
`timescale 1ns / 1ps
interface hsga_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] grad_prefix;
  logic        [30:0] hess_prefix;
  logic               last_bin;
  modport source (output valid, grad_prefix, hess_prefix, last_bin, input ready);
  modport sink   (input valid, grad_prefix, hess_prefix, last_bin, output ready);
endinterface

interface hsga_out_if;
  logic               valid;
  logic               ready;
  logic signed [8:0]  best_bin;
  logic        [46:0] split_gain;
  logic signed [31:0] best_grad_left;
  logic        [30:0] best_hess_left;
  logic               too_many_bins;
  modport source (output valid, best_bin, split_gain, best_grad_left, best_hess_left,
                  too_many_bins, input ready);
  modport sink   (input valid, best_bin, split_gain, best_grad_left, best_hess_left,
                  too_many_bins, output ready);
endinterface

interface hsga_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/hsga_ctrl.sv
// Sequencing state machine for the split gain search.
// Depends on hsga_pkg.
`timescale 1ns / 1ps
module hsga_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hsga_pkg::sts_t sts_i,
  output hsga_pkg::cmd_t cmd_o
);
  import hsga_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] term_q, term_d;

  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    cmd_o   = '0;
    cmd_o.term = term_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        term_d = TERM_LEFT;
        if (sts_i.skip) begin
          cmd_o.flag_ovf = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_ACC;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (term_q == TERM_PARENT) begin
          state_d = ST_UPD;
        end else begin
          term_d  = term_q + 2'd1;
          state_d = ST_PREP;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        state_d = sts_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      term_q  <= TERM_LEFT;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
    end
  end
endmodule

FILE: rtl/hsga_dp.sv
// Datapath: configuration registers, term squaring, shared restoring divider,
// gain accumulation, running argmax and result register. Depends on hsga_pkg.
`timescale 1ns / 1ps
module hsga_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [31:0] grad_prefix_i,
  input  logic [30:0]        hess_prefix_i,
  input  logic               last_bin_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [8:0]  best_bin_o,
  output logic [46:0]        split_gain_o,
  output logic signed [31:0] best_grad_left_o,
  output logic [30:0]        best_hess_left_o,
  output logic               too_many_bins_o,
  input  hsga_pkg::cmd_t     cmd_i,
  output hsga_pkg::sts_t     sts_o
);
  import hsga_pkg::*;

  logic signed [31:0] pg_q;
  logic [30:0] ph_q, lam_q, mch_q;
  logic signed [31:0] gl_q;
  logic [30:0] hl_q;
  logic last_q;

  logic [63:0] quo_q;
  logic [32:0] rem_q, den_q;
  logic dz_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic signed [49:0] acc_q;

  logic [CNT_W-1:0] cnt_q;
  logic signed [8:0] bbin_q;
  logic [46:0] bgain_q;
  logic signed [31:0] bgrad_q;
  logic [30:0] bhess_q;
  logic ovf_q;
  logic out_valid_q;

  logic signed [32:0] hr, g_sel, g_abs;
  logic signed [33:0] d_sel;
  logic [31:0] mag;
  logic [33:0] rem_sh;
  logic ge;
  logic [46:0] term_val;
  logic signed [49:0] gain_c, gain_f;
  logic split_ok;

  assign hr = $signed({2'b00, ph_q}) - $signed({2'b00, hl_q});

  always_comb begin
    case (cmd_i.term)
      TERM_LEFT: begin
        g_sel = {gl_q[31], gl_q};
        d_sel = $signed({3'b000, hl_q}) + $signed({3'b000, lam_q});
      end
      TERM_RIGHT: begin
        g_sel = $signed({pg_q[31], pg_q}) - $signed({gl_q[31], gl_q});
        d_sel = $signed({hr[32], hr}) + $signed({3'b000, lam_q});
      end
      default: begin
        g_sel = {pg_q[31], pg_q};
        d_sel = $signed({3'b000, ph_q}) + $signed({3'b000, lam_q});
      end
    endcase
  end

  assign g_abs = g_sel[32] ? -g_sel : g_sel;
  assign mag   = g_abs[31:0];

  assign rem_sh = {rem_q, quo_q[63]};
  assign ge     = rem_sh >= {1'b0, den_q};

  assign term_val = (dz_q || (|quo_q[63:47])) ? TERM_MAX : quo_q[46:0];

  assign gain_c   = (acc_q > $signed({3'b000, TERM_MAX})) ? $signed({3'b000, TERM_MAX})
                                                          : acc_q;
  assign split_ok = ({2'b00, hl_q} >= {2'b00, mch_q}) && (hr >= $signed({2'b00, mch_q}));
  assign gain_f   = split_ok ? gain_c : INVALID_GAIN;

  assign sts_o.skip     = cnt_q >= CNT_W'(MAX_BINS);
  assign sts_o.last     = last_q;
  assign sts_o.div_done = dcnt_q == DCNT_W'(DIV_STEPS);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pg_q  <= '0;
      ph_q  <= '0;
      lam_q <= 31'd65536;
      mch_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PARENT_GRAD: pg_q  <= cfg_data_i;
        REG_PARENT_HESS: ph_q  <= cfg_data_i[30:0];
        REG_L2_LAMBDA:   lam_q <= cfg_data_i[30:0];
        REG_MIN_HESS:    mch_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      gl_q   <= grad_prefix_i;
      hl_q   <= hess_prefix_i;
      last_q <= last_bin_i;
    end
    if (cmd_i.prep) begin
      quo_q  <= {32'd0, mag} * {32'd0, mag};
      den_q  <= d_sel[32:0];
      dz_q   <= d_sel[33] || (d_sel == '0);
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? 33'(rem_sh - {1'b0, den_q}) : rem_sh[32:0];
      quo_q  <= {quo_q[62:0], ge};
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
    if (cmd_i.load_item) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      if (cmd_i.term == TERM_PARENT) begin
        acc_q <= acc_q - $signed({3'b000, term_val});
      end else begin
        acc_q <= acc_q + $signed({3'b000, term_val});
      end
    end
    if (cmd_i.emit) begin
      best_bin_o       <= bbin_q;
      split_gain_o     <= bgain_q;
      best_grad_left_o <= bgrad_q;
      best_hess_left_o <= bhess_q;
      too_many_bins_o  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      bbin_q      <= -9'sd1;
      bgain_q     <= '0;
      bgrad_q     <= '0;
      bhess_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.flag_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.update) begin
        if (gain_f > $signed({3'b000, bgain_q})) begin
          bgain_q <= gain_f[46:0];
          bbin_q  <= 9'(cnt_q);
          bgrad_q <= gl_q;
          bhess_q <= hl_q;
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        cnt_q       <= '0;
        bbin_q      <= -9'sd1;
        bgain_q     <= '0;
        bgrad_q     <= '0;
        bhess_q     <= '0;
        ovf_q       <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

FILE: rtl/histogram_split_gain_argmax.sv
// Best split search over one feature histogram. For every input bin, three
// squared-over-hessian terms share one restoring divider; each term is squared
// and loaded, takes 64 quotient bits at one per cycle, ends, and is accumulated.
// Each bin also passes the idle, check, argmax update and finish states; a bin
// that closes a histogram also passes emit, which waits while the previous
// result is still held. Bins past capacity skip the terms (idle, check, finish,
// and emit when closing). A result is held in an output register, so the next
// histogram's first bin may be taken while the previous result waits. Config is
// always ready. Depends on hsga_pkg, hsga_if, hsga_ctrl, hsga_dp.
`timescale 1ns / 1ps
module histogram_split_gain_argmax (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsga_in_if.sink      in_i,
  hsga_out_if.source   out_o,
  hsga_cfg_if.sink     cfg_i
);
  import hsga_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  hsga_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hsga_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .grad_prefix_i    (in_i.grad_prefix),
    .hess_prefix_i    (in_i.hess_prefix),
    .last_bin_i       (in_i.last_bin),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .best_bin_o       (out_o.best_bin),
    .split_gain_o     (out_o.split_gain),
    .best_grad_left_o (out_o.best_grad_left),
    .best_hess_left_o (out_o.best_hess_left),
    .too_many_bins_o  (out_o.too_many_bins),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );
endmodule
